// ===== rtl/gci_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gci_pkg
// shared constants and types for the grid cell indexer
// ---------------------------------------------------------------------------
package gci_pkg;

  localparam int SIDE_BITS = 6;
  localparam int MAX_SIDE = 64;
  localparam int IDX_BITS = 12;
  localparam int MAX_CELLS = 4096;
  localparam int SLOT_BITS = 2 * SIDE_BITS;
  localparam int MAX_RADIUS = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QCOORD = 2'd1;
  localparam logic [1:0] OP_QINDEX = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NOINDEX = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_GRID_W = 3'd3;
  localparam logic [2:0] REG_GRID_H = 3'd4;

  typedef struct packed {
    logic start;
    logic [32:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/grid_cell_indexer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// grid_cell_indexer
// bins 2d points into a uniform grid and streams occupied neighbor cells
// ---------------------------------------------------------------------------
// insert: two passes through the shared divider, x then y, then a map read and
//   update; a point outside the grid answers after the second divider pass
// query by coordinates: a setup step, then a read, wait and check per window cell
//   (at most 49); by index the cell is read from the list first, and an unassigned index answers without that read
// busy covers the whole item, the next word is taken once the last result is out;
//   results are one-cycle strobes and the receiver cannot stall
// after reset a clearing pass empties every occupancy map entry, busy high meanwhile
module grid_cell_indexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic [5:0]  in_query_cell_x,
  input  wire logic [5:0]  in_query_cell_y,
  input  wire logic [11:0] in_query_index,
  input  wire logic [1:0]  in_radius,
  output logic             out_valid,
  output logic [5:0]       out_cell_x,
  output logic [5:0]       out_cell_y,
  output logic [11:0]      out_cell_index,
  output logic             out_is_new,
  output logic             out_found,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SB = gci_pkg::SIDE_BITS;
  localparam int IB = gci_pkg::IDX_BITS;
  localparam int LB = gci_pkg::SLOT_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIVX, S_DIVY, S_INS_RD, S_INS_WAIT, S_INS_DO,
    S_LIST_WAIT, S_Q_SETUP, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_DO, S_EMIT
  } state_t;

  // configuration
  logic [31:0] origin_x_r, origin_y_r;
  logic [15:0] cell_size_r;
  logic [6:0]  grid_w_r, grid_h_r;
  logic [2:0]  reg_sel;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cell_size_r <= 16'd1;
      grid_w_r <= 7'd64;
      grid_h_r <= 7'd64;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        gci_pkg::REG_ORIGIN_X:  origin_x_r <= pwdata;
        gci_pkg::REG_ORIGIN_Y:  origin_y_r <= pwdata;
        gci_pkg::REG_CELL_SIZE: cell_size_r <= pwdata[15:0];
        gci_pkg::REG_GRID_W:    grid_w_r <= pwdata[6:0];
        gci_pkg::REG_GRID_H:    grid_h_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gci_pkg::REG_ORIGIN_X:  prdata = origin_x_r;
      gci_pkg::REG_ORIGIN_Y:  prdata = origin_y_r;
      gci_pkg::REG_CELL_SIZE: prdata = {16'd0, cell_size_r};
      gci_pkg::REG_GRID_W:    prdata = {25'd0, grid_w_r};
      gci_pkg::REG_GRID_H:    prdata = {25'd0, grid_h_r};
      default:                prdata = '0;
    endcase
  end

  logic [6:0] eff_w, eff_h;
  assign eff_w = (grid_w_r > 7'd64) ? 7'd64 : grid_w_r;
  assign eff_h = (grid_h_r > 7'd64) ? 7'd64 : grid_h_r;

  // memories
  logic [IB:0]   occ_mem [gci_pkg::MAX_CELLS];
  logic [2*SB-1:0] list_mem [gci_pkg::MAX_CELLS];
  logic          occ_we;
  logic [LB-1:0] occ_waddr, occ_raddr;
  logic [IB:0]   occ_wdata, occ_rdata_r;
  logic          list_we;
  logic [IB-1:0] list_waddr, list_raddr;
  logic [2*SB-1:0] list_wdata, list_rdata_r;

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    occ_rdata_r <= occ_mem[occ_raddr];
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_rdata_r <= list_mem[list_raddr];
  end

  // shared divider
  gci_pkg::div_req_t div_req;
  gci_pkg::div_rsp_t div_rsp;
  gci_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  state_t        state_r, state_nxt;
  logic [LB-1:0] clr_r, clr_nxt;
  logic [IB:0]   count_r, count_nxt;
  logic [31:0]   py_r, py_nxt;
  logic          xneg_r, xneg_nxt;
  logic          go_r, go_nxt;
  logic [6:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0]    rad_r, rad_nxt;
  logic [6:0]    x_r, x_nxt, y_r, y_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic          pend_r, pend_nxt;
  logic [5:0]    px_r, px_nxt, pyc_r, pyc_nxt;
  logic [IB-1:0] pidx_r, pidx_nxt;
  logic          ov_r, ov_nxt;
  logic [5:0]    ox_r, ox_nxt, oy_r, oy_nxt;
  logic [IB-1:0] oidx_r, oidx_nxt;
  logic          onew_r, onew_nxt, ofound_r, ofound_nxt, olast_r, olast_nxt;
  logic [1:0]    ost_r, ost_nxt;

  logic [32:0] diff;
  logic        dneg;
  logic [32:0] dmag;
  logic [15:0] dsize;
  logic [32:0] q;
  logic        axis_ok;
  logic [6:0]  side;
  logic [7:0]  lo_t, hi_t;
  logic        next_in_window;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    count_nxt = count_r;
    py_nxt = py_r;
    xneg_nxt = xneg_r;
    go_nxt = go_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    rad_nxt = rad_r;
    x_nxt = x_r;
    y_nxt = y_r;
    y0_nxt = y0_r;
    x1_nxt = x1_r;
    y1_nxt = y1_r;
    pend_nxt = pend_r;
    px_nxt = px_r;
    pyc_nxt = pyc_r;
    pidx_nxt = pidx_r;
    ov_nxt = 1'b0;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    oidx_nxt = oidx_r;
    onew_nxt = onew_r;
    ofound_nxt = ofound_r;
    ost_nxt = ost_r;
    olast_nxt = olast_r;
    occ_we = 1'b0;
    occ_waddr = clr_r;
    occ_wdata = '0;
    occ_raddr = {y_r[SB-1:0], x_r[SB-1:0]};
    list_we = 1'b0;
    list_waddr = count_r[IB-1:0];
    list_wdata = {cy_r[SB-1:0], cx_r[SB-1:0]};
    list_raddr = in_query_index;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = '0;
    dsize = (cell_size_r == 16'd0) ? 16'd1 : cell_size_r;
    diff = '0;
    dneg = 1'b0;
    dmag = '0;
    q = div_rsp.quotient;
    side = (state_r == S_DIVX) ? eff_w : eff_h;
    axis_ok = ((!xneg_r) || (q == 33'd0)) && (q < {26'd0, side});
    lo_t = '0;
    hi_t = '0;
    next_in_window = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        occ_we = 1'b1;
        occ_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          rad_nxt = in_radius;
          pend_nxt = 1'b0;
          go_nxt = 1'b1;
          unique case (in_opcode)
            gci_pkg::OP_INSERT: begin
              diff = {in_point_x[31], in_point_x} - {origin_x_r[31], origin_x_r};
              dneg = diff[32];
              dmag = dneg ? (33'd0 - diff) : diff;
              div_req.start = 1'b1;
              div_req.dividend = dmag;
              div_req.divisor = dsize;
              xneg_nxt = dneg;
              py_nxt = in_point_y;
              state_nxt = S_DIVX;
            end
            gci_pkg::OP_QCOORD: begin
              cx_nxt = {1'b0, in_query_cell_x};
              cy_nxt = {1'b0, in_query_cell_y};
              state_nxt = S_Q_SETUP;
            end
            gci_pkg::OP_QINDEX: begin
              list_raddr = in_query_index;
              if ({1'b0, in_query_index} >= count_r) begin
                ov_nxt = 1'b1;
                ox_nxt = '0;
                oy_nxt = '0;
                oidx_nxt = '0;
                onew_nxt = 1'b0;
                ofound_nxt = 1'b0;
                ost_nxt = gci_pkg::ST_NOINDEX;
                olast_nxt = 1'b1;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_LIST_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIVX: begin
        if (div_rsp.done) begin
          go_nxt = axis_ok;
          cx_nxt = q[6:0];
          diff = {py_r[31], py_r} - {origin_y_r[31], origin_y_r};
          dneg = diff[32];
          dmag = dneg ? (33'd0 - diff) : diff;
          div_req.start = 1'b1;
          div_req.dividend = dmag;
          div_req.divisor = dsize;
          xneg_nxt = dneg;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_rsp.done) begin
          cy_nxt = q[6:0];
          if (!(go_r && axis_ok)) begin
            ov_nxt = 1'b1;
            ox_nxt = '0;
            oy_nxt = '0;
            oidx_nxt = '0;
            onew_nxt = 1'b0;
            ofound_nxt = 1'b0;
            ost_nxt = gci_pkg::ST_OUTSIDE;
            olast_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        occ_raddr = {cy_r[SB-1:0], cx_r[SB-1:0]};
        state_nxt = S_INS_WAIT;
      end
      S_INS_WAIT: begin
        occ_raddr = {cy_r[SB-1:0], cx_r[SB-1:0]};
        state_nxt = S_INS_DO;
      end
      S_INS_DO: begin
        ov_nxt = 1'b1;
        olast_nxt = 1'b1;
        onew_nxt = 1'b0;
        state_nxt = S_EMIT;
        if (occ_rdata_r[IB]) begin
          ox_nxt = cx_r[SB-1:0];
          oy_nxt = cy_r[SB-1:0];
          oidx_nxt = occ_rdata_r[IB-1:0];
          ofound_nxt = 1'b1;
          ost_nxt = gci_pkg::ST_OK;
        end else if (count_r[IB]) begin
          ox_nxt = '0;
          oy_nxt = '0;
          oidx_nxt = '0;
          ofound_nxt = 1'b0;
          ost_nxt = gci_pkg::ST_OUTSIDE;
        end else begin
          occ_we = 1'b1;
          occ_waddr = {cy_r[SB-1:0], cx_r[SB-1:0]};
          occ_wdata = {1'b1, count_r[IB-1:0]};
          list_we = 1'b1;
          ox_nxt = cx_r[SB-1:0];
          oy_nxt = cy_r[SB-1:0];
          oidx_nxt = count_r[IB-1:0];
          onew_nxt = 1'b1;
          ofound_nxt = 1'b1;
          ost_nxt = gci_pkg::ST_OK;
          count_nxt = count_r + 1'b1;
        end
      end
      S_LIST_WAIT: begin
        cx_nxt = {1'b0, list_rdata_r[SB-1:0]};
        cy_nxt = {1'b0, list_rdata_r[2*SB-1:SB]};
        state_nxt = S_Q_SETUP;
      end
      S_Q_SETUP: begin
        // clip window to the grid
        lo_t = {1'b0, cx_r} - {6'd0, rad_r};
        x_nxt = lo_t[7] ? 7'd0 : lo_t[6:0];
        hi_t = {1'b0, cx_r} + {6'd0, rad_r} + 8'd1;
        x1_nxt = (hi_t < {1'b0, eff_w}) ? hi_t[6:0] : eff_w;
        lo_t = {1'b0, cy_r} - {6'd0, rad_r};
        y0_nxt = lo_t[7] ? 7'd0 : lo_t[6:0];
        y_nxt = lo_t[7] ? 7'd0 : lo_t[6:0];
        hi_t = {1'b0, cy_r} + {6'd0, rad_r} + 8'd1;
        y1_nxt = (hi_t < {1'b0, eff_h}) ? hi_t[6:0] : eff_h;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (x_r >= x1_r || y_r >= y1_r) begin
          // window empty or done: flush held word as last
          ov_nxt = 1'b1;
          olast_nxt = 1'b1;
          onew_nxt = 1'b0;
          if (pend_r) begin
            ox_nxt = px_r;
            oy_nxt = pyc_r;
            oidx_nxt = pidx_r;
            ofound_nxt = 1'b1;
          end else begin
            ox_nxt = '0;
            oy_nxt = '0;
            oidx_nxt = '0;
            ofound_nxt = 1'b0;
          end
          ost_nxt = gci_pkg::ST_OK;
          state_nxt = S_EMIT;
        end else begin
          occ_raddr = {y_r[SB-1:0], x_r[SB-1:0]};
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: state_nxt = S_SCAN_DO;
      S_SCAN_DO: begin
        if (occ_rdata_r[IB]) begin
          // hold one hit back so the final one can carry last
          if (pend_r) begin
            ov_nxt = 1'b1;
            ox_nxt = px_r;
            oy_nxt = pyc_r;
            oidx_nxt = pidx_r;
            onew_nxt = 1'b0;
            ofound_nxt = 1'b1;
            ost_nxt = gci_pkg::ST_OK;
            olast_nxt = 1'b0;
          end
          pend_nxt = 1'b1;
          px_nxt = x_r[SB-1:0];
          pyc_nxt = y_r[SB-1:0];
          pidx_nxt = occ_rdata_r[IB-1:0];
        end
        next_in_window = (y_r + 7'd1) < y1_r;
        if (next_in_window) begin
          y_nxt = y_r + 7'd1;
        end else begin
          y_nxt = y0_r;
          x_nxt = x_r + 7'd1;
        end
        state_nxt = S_SCAN_RD;
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      count_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      pend_r <= pend_nxt;
    end
    py_r <= py_nxt;
    xneg_r <= xneg_nxt;
    go_r <= go_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    rad_r <= rad_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    y0_r <= y0_nxt;
    x1_r <= x1_nxt;
    y1_r <= y1_nxt;
    px_r <= px_nxt;
    pyc_r <= pyc_nxt;
    pidx_r <= pidx_nxt;
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    oidx_r <= oidx_nxt;
    onew_r <= onew_nxt;
    ofound_r <= ofound_nxt;
    ost_r <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_cell_x = ox_r;
  assign out_cell_y = oy_r;
  assign out_cell_index = oidx_r;
  assign out_is_new = onew_r;
  assign out_found = ofound_r;
  assign out_status = ost_r;
  assign out_last = olast_r;

endmodule
`default_nettype wire

// ===== rtl/gci_divider.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gci_divider
// restoring unsigned divider, one quotient bit per cycle for a 33-bit quotient
// ---------------------------------------------------------------------------
module gci_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gci_pkg::div_req_t req,
  output gci_pkg::div_rsp_t      rsp
);

  logic [32:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[32]} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[17]) begin
        rem_nxt = {rem_r[15:0], quo_r[32]};
        quo_nxt = {quo_r[31:0], 1'b0};
      end else begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire
